@@ rtl/smcp_pkg.sv @@
// Shared types, codes and the fixed key table of the key/value port.
package smcp_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int OSK_WORDS  = 8;

    typedef logic [OSK_WORDS-1:0][CFG_DATA_W-1:0] t_osk;

    // Host operations
    localparam logic [2:0] OP_DATA_WRITE = 3'd0;
    localparam logic [2:0] OP_DATA_READ  = 3'd1;
    localparam logic [2:0] OP_CMD_WRITE  = 3'd2;
    localparam logic [2:0] OP_STAT_READ  = 3'd3;
    localparam logic [2:0] OP_ERR_READ   = 3'd4;
    localparam logic [2:0] OP_ERR_WRITE  = 3'd5;

    // Commands
    localparam logic [7:0] CMD_READ_VALUE = 8'h10;
    localparam logic [7:0] CMD_READ_TYPE  = 8'h13;

    // Status flags
    localparam logic [7:0] ST_DATA_READY = 8'h01;
    localparam logic [7:0] ST_ACK        = 8'h04;
    localparam logic [7:0] ST_NEW_CMD    = 8'h08;

    // Error codes
    localparam logic [7:0] ERR_NONE        = 8'h00;
    localparam logic [7:0] ERR_INTERRUPTED = 8'h80;
    localparam logic [7:0] ERR_STILL_BAD   = 8'h81;
    localparam logic [7:0] ERR_BAD_CMD     = 8'h82;
    localparam logic [7:0] ERR_NO_KEY      = 8'h84;

    // Key table
    localparam int TABLE_SIZE = 6;
    localparam int KEY_COUNT  = 6;
    localparam int KEY_LIMIT  = (KEY_COUNT > TABLE_SIZE) ? TABLE_SIZE : KEY_COUNT;

    localparam logic [2:0] KEY_REV  = 3'd0;
    localparam logic [2:0] KEY_OSK0 = 3'd1;
    localparam logic [2:0] KEY_OSK1 = 3'd2;
    localparam logic [2:0] KEY_NATJ = 3'd3;
    localparam logic [2:0] KEY_MSSP = 3'd4;
    localparam logic [2:0] KEY_MSSD = 3'd5;

    localparam logic [7:0] TYPE_REPLY_LEN = 8'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_STAGE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic accept;
        logic match;
        logic stage_wr;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic lookup_due;
        logic read_due;
        logic hit;
        logic stage_last;
    } t_dp_status;

    // Key names, first character in the lowest byte
    function automatic logic [31:0] key_name(input logic [2:0] entry);
        logic [31:0] name;
        case (entry)
            KEY_REV:  name = 32'h20564552;
            KEY_OSK0: name = 32'h304B534F;
            KEY_OSK1: name = 32'h314B534F;
            KEY_NATJ: name = 32'h4A54414E;
            KEY_MSSP: name = 32'h5053534D;
            KEY_MSSD: name = 32'h4453534D;
            default:  name = 32'h0;
        endcase
        return name;
    endfunction

    function automatic logic [7:0] key_len(input logic [2:0] entry);
        logic [7:0] len;
        case (entry)
            KEY_REV:            len = 8'd6;
            KEY_OSK0, KEY_OSK1: len = 8'd32;
            default:            len = 8'd1;
        endcase
        return len;
    endfunction

    function automatic logic [31:0] key_type(input logic [2:0] entry);
        logic [31:0] tname;
        case (entry)
            KEY_REV:            tname = 32'h7665727B;
            KEY_OSK0, KEY_OSK1: tname = 32'h2A386975;
            default:            tname = 32'h20386975;
        endcase
        return tname;
    endfunction

    function automatic logic [7:0] rev_byte(input logic [7:0] idx);
        logic [7:0] b;
        case (idx)
            8'd0:    b = 8'h01;
            8'd1:    b = 8'h13;
            8'd2:    b = 8'h0f;
            8'd5:    b = 8'h03;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] osk_byte(input t_osk osk, input logic [5:0] idx);
        return osk[idx[5:3]][{idx[2:0], 3'b000} +: 8];
    endfunction

    // One byte of the reply for the matched entry
    function automatic logic [7:0] stage_byte(input logic [2:0] entry, input logic is_type,
                                              input logic [7:0] idx, input t_osk osk);
        logic [31:0] tname;
        logic [7:0]  b;
        tname = key_type(entry);
        if (is_type) begin
            case (idx)
                8'd0:    b = key_len(entry);
                8'd1:    b = tname[7:0];
                8'd2:    b = tname[15:8];
                8'd3:    b = tname[23:16];
                8'd4:    b = tname[31:24];
                default: b = 8'h00;
            endcase
        end else begin
            case (entry)
                KEY_REV:  b = rev_byte(idx);
                KEY_OSK0: b = osk_byte(osk, {1'b0, idx[4:0]});
                KEY_OSK1: b = osk_byte(osk, {1'b1, idx[4:0]});
                default:  b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

@@ rtl/smcp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module smcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/smcp_cfg.sv @@
// APB register file holding the eight OS key words.
module smcp_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smcp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [smcp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [smcp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output smcp_pkg::t_osk                 o_osk
);
    import smcp_pkg::*;

    t_osk r_osk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osk <= '0;
        end else if (psel && penable && pwrite) begin
            r_osk[paddr[CFG_ADDR_W-1:3]] <= pwdata;
        end
    end

    assign prdata = r_osk[paddr[CFG_ADDR_W-1:3]];
    assign pready = 1'b1;
    assign o_osk  = r_osk;

endmodule

@@ rtl/smcp_ctrl.sv @@
// Controller: handshakes, sequencing of match, staging and reply reads.
module smcp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  smcp_pkg::t_dp_status  i_status,
    output smcp_pkg::t_dp_cmd     o_cmd
);
    import smcp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   ready;
    logic   push;

    assign ready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        push    = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid && ready) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.lookup_due) begin
                        n_state = ST_MATCH;
                    end else if (i_status.read_due) begin
                        n_state = ST_READ;
                    end else begin
                        push = 1'b1;
                    end
                end
            end
            ST_MATCH: begin
                o_cmd.match = 1'b1;
                if (i_status.hit) begin
                    n_state = ST_STAGE;
                end else begin
                    push    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_STAGE: begin
                o_cmd.stage_wr = 1'b1;
                if (i_status.stage_last) begin
                    push    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                o_cmd.capture = 1'b1;
                push          = 1'b1;
                n_state       = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = (r_out_valid && !i_m_axis_tready) || push;
    end

    assign o_s_axis_tready = ready;
    assign o_m_axis_tvalid = r_out_valid;

    // The output slot is empty whenever an item is still being worked on
    a_busy_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("result pending while an item is in progress");

    // Staging is entered only from a successful match
    a_stage_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STAGE) |-> ($past(r_state) == ST_MATCH || $past(r_state) == ST_STAGE))
        else $error("staging entered without a match");

    // A reply read always delivers its byte on the next cycle
    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> r_out_valid)
        else $error("reply read produced no result");

endmodule

@@ rtl/smcp_dp.sv @@
// Datapath: port state, key match, reply staging and the reply buffer.
module smcp_dp #(
    parameter int REPLY_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [2:0]           i_operation,
    input  logic [7:0]           i_write_data,
    input  smcp_pkg::t_osk       i_osk,
    input  smcp_pkg::t_dp_cmd    i_cmd,
    output smcp_pkg::t_dp_status o_status,
    output logic [7:0]           o_read_data
);
    import smcp_pkg::*;

    localparam int         AW        = $clog2(REPLY_BYTES);
    localparam logic [7:0] REPLY_MAX = 8'(REPLY_BYTES);

    logic [7:0]      r_active_cmd, n_active_cmd;
    logic [7:0]      r_status, n_status;
    logic [7:0]      r_error, n_error;
    logic [7:0]      r_last;
    logic [3:0][7:0] r_key, n_key;
    logic [7:0]      r_wpos, n_wpos;
    logic [7:0]      r_rlen, n_rlen;
    logic [7:0]      r_rpos, n_rpos;
    logic [2:0]      r_entry;
    logic            r_is_type;
    logic [AW-1:0]   r_stage_idx;
    logic [7:0]      r_out_data;

    logic            cmd_valid;
    logic [7:0]      wpos_target;
    logic            m_hit;
    logic [2:0]      m_entry;
    logic [7:0]      m_len;
    logic [7:0]      entry_len;
    logic [7:0]      result;
    logic [7:0]      ram_rdata;
    logic [7:0]      stage_data;

    assign cmd_valid   = (r_active_cmd == CMD_READ_VALUE) || (r_active_cmd == CMD_READ_TYPE);
    assign wpos_target = (r_active_cmd == CMD_READ_VALUE) ? 8'd4 : 8'd3;

    // Search the table against the stored key
    always_comb begin
        m_hit   = 1'b0;
        m_entry = '0;
        for (int i = 0; i < KEY_LIMIT; i++) begin
            if (!m_hit && (r_key == key_name(3'(i)))) begin
                m_hit   = 1'b1;
                m_entry = 3'(i);
            end
        end
    end

    assign entry_len = key_len(m_entry);
    assign m_len = (r_active_cmd == CMD_READ_TYPE) ? TYPE_REPLY_LEN :
                   ((entry_len > REPLY_MAX) ? REPLY_MAX : entry_len);

    assign o_status.lookup_due = (i_operation == OP_DATA_WRITE) && cmd_valid &&
                                 (r_status[3:0] != 4'd0) && (r_wpos == wpos_target);
    assign o_status.read_due   = (i_operation == OP_DATA_READ) && cmd_valid &&
                                 r_status[0] && (r_rpos < r_rlen);
    assign o_status.hit        = m_hit;
    assign o_status.stage_last = (8'(r_stage_idx) == 8'(r_rlen - 8'd1));

    // Apply one accepted transaction, or the outcome of a match
    always_comb begin
        n_active_cmd = r_active_cmd;
        n_status     = r_status;
        n_error      = r_error;
        n_key        = r_key;
        n_wpos       = r_wpos;
        n_rlen       = r_rlen;
        n_rpos       = r_rpos;
        result       = 8'h00;
        if (i_cmd.accept) begin
            case (i_operation)
                OP_DATA_WRITE: begin
                    if (!cmd_valid) begin
                        n_status = 8'h00;
                        n_error  = ERR_STILL_BAD;
                    end else if (r_status[3:0] != 4'd0) begin
                        if (r_wpos < 8'd4) begin
                            n_key[r_wpos[1:0]] = i_write_data;
                            n_status           = ST_ACK;
                        end
                        n_wpos = 8'(r_wpos + 8'd1);
                    end
                end
                OP_DATA_READ: begin
                    if (!cmd_valid) begin
                        n_status = 8'h00;
                        n_error  = ERR_STILL_BAD;
                    end else if (o_status.read_due) begin
                        n_rpos   = 8'(r_rpos + 8'd1);
                        n_status = (8'(r_rpos + 8'd1) == r_rlen) ? 8'h00 :
                                   (ST_ACK | ST_DATA_READY);
                    end
                    result = r_last;
                end
                OP_CMD_WRITE: begin
                    if ((i_write_data == CMD_READ_VALUE) || (i_write_data == CMD_READ_TYPE)) begin
                        if ((r_status[3:0] == 4'd0) || (r_status[3:0] == ST_NEW_CMD[3:0])) begin
                            n_active_cmd = i_write_data;
                            n_status     = ST_NEW_CMD | ST_ACK;
                        end else begin
                            n_status = ST_NEW_CMD;
                            n_error  = ERR_INTERRUPTED;
                        end
                    end else begin
                        n_status = ST_NEW_CMD;
                        n_error  = ERR_BAD_CMD;
                    end
                    n_wpos = 8'h00;
                    n_rpos = 8'h00;
                end
                OP_STAT_READ: result = r_status;
                OP_ERR_READ:  result = r_error;
                default:      result = 8'h00;
            endcase
        end
        if (i_cmd.match) begin
            if (m_hit) begin
                n_status = ST_ACK | ST_DATA_READY;
                n_error  = ERR_NONE;
                n_rpos   = 8'h00;
                n_rlen   = m_len;
            end else begin
                n_status = 8'h00;
                n_error  = ERR_NO_KEY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_cmd <= 8'h00;
            r_status     <= 8'h00;
            r_error      <= 8'h00;
            r_last       <= 8'h00;
            r_key        <= '0;
            r_wpos       <= 8'h00;
            r_rlen       <= 8'h00;
            r_rpos       <= 8'h00;
            r_entry      <= '0;
            r_is_type    <= 1'b0;
            r_stage_idx  <= '0;
        end else begin
            r_active_cmd <= n_active_cmd;
            r_status     <= n_status;
            r_error      <= n_error;
            r_key        <= n_key;
            r_wpos       <= n_wpos;
            r_rlen       <= n_rlen;
            r_rpos       <= n_rpos;
            if (i_cmd.match) begin
                r_entry     <= m_entry;
                r_is_type   <= (r_active_cmd == CMD_READ_TYPE);
                r_stage_idx <= '0;
            end
            if (i_cmd.stage_wr) begin
                r_stage_idx <= AW'(r_stage_idx + 1'b1);
            end
            if (i_cmd.capture) begin
                r_last <= ram_rdata;
            end
        end
    end

    // Result byte; a reply read overwrites it once the buffer data is out
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out_data <= result;
        end else if (i_cmd.capture) begin
            r_out_data <= ram_rdata;
        end
    end

    assign stage_data = stage_byte(r_entry, r_is_type, 8'(r_stage_idx), i_osk);

    smcp_ram #(
        .WIDTH (8),
        .DEPTH (REPLY_BYTES)
    ) u_reply_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.stage_wr),
        .i_waddr (r_stage_idx),
        .i_wdata (stage_data),
        .i_raddr (r_rpos[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_read_data = r_out_data;

endmodule

@@ rtl/smc_key_value_port.sv @@
// Top level of the byte-wide key/value port device.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         i_s_axis_tvalid/o_..._tready host transaction: operation, write byte
//  m_axis    out        o_m_axis_tvalid/i_..._tready returned byte, one per input transaction
//  apb       in         psel/penable/pwrite, pready  OS key words 0..7 at byte address 8*i
//
// Status, error, command, error-write and plain data-write transactions are answered from
// the idle state. A data read that returns a staged byte passes the read state for the
// registered read of the reply buffer. A data write that starts the key lookup passes the
// match state and, on a hit, one buffer write a cycle (up to 32 for OSK0/OSK1).
// Reset: synchronous, active low; clears port state but the result byte, not the reply
// buffer, which needs no clearing pass. Stalls: the result sits in an output register;
// a new transaction is taken while it waits as long as the register empties that cycle.
module smc_key_value_port #(
    parameter int REPLY_BYTES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input transaction
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [2:0] operation, [10:3] write_data, [15:11] zero
    input  logic [15:0]                     i_s_axis_tdata,
    // Result transaction
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] read_data
    output logic [7:0]                      o_m_axis_tdata,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [smcp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [smcp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [smcp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import smcp_pkg::*;

    t_osk       osk;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Key words feed the staging path directly; the user must write them only while idle, the block does not enforce it
    smcp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_osk   (osk)
    );

    // Sequence each transaction and own both handshakes
    smcp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_status        (dp_status),
        .o_cmd           (dp_cmd)
    );

    // Port state, key match and reply buffer
    smcp_dp #(
        .REPLY_BYTES (REPLY_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_operation  (i_s_axis_tdata[2:0]),
        .i_write_data (i_s_axis_tdata[10:3]),
        .i_osk        (osk),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .o_read_data  (o_m_axis_tdata)
    );

endmodule
